@@ hw/rtl/eavf_pkg.sv @@
// shared types, constants and coefficient table for the encoder angle velocity filter
package eavf_pkg;

	localparam int TURN_UNITS = 23040;
	localparam int HALF_COEFS = 17;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UNWRAP,
		ST_FIR,
		ST_FINISH,
		ST_VEL,
		ST_AVG1,
		ST_AVG2,
		ST_OUT
	} state_t;

	typedef enum logic [0:0] {
		REG_SAMPLE_RATE = 1'b0,
		REG_WRAP_THRESHOLD = 1'b1
	} reg_index_t;

	// half-filter coefficients in units of 1e-12
	function automatic logic signed [39:0] coef_e12(input logic [4:0] j);
		logic signed [39:0] c;
		begin
			case (j)
				5'd0: c = 40'sd298910;
				5'd1: c = 40'sd1959461;
				5'd2: c = 40'sd2847098;
				5'd3: c = -40'sd25211439;
				5'd4: c = -40'sd195788766;
				5'd5: c = -40'sd789310970;
				5'd6: c = -40'sd2259462042;
				5'd7: c = -40'sd4986784693;
				5'd8: c = -40'sd8656045842;
				5'd9: c = -40'sd11429277453;
				5'd10: c = -40'sd9517036757;
				5'd11: c = 40'sd2063978790;
				5'd12: c = 40'sd27224499002;
				5'd13: c = 40'sd65794886477;
				5'd14: c = 40'sd111565845660;
				5'd15: c = 40'sd153155814566;
				5'd16: c = 40'sd178048771809;
				default: c = 40'sd0;
			endcase
			return c;
		end
	endfunction

	// coefficient scaled to the given fraction bits, rounded half away from zero
	function automatic longint coef_scaled(input int j, input int bits);
		longint c;
		longint mag;
		longint q;
		begin
			if (j < 0 || j >= HALF_COEFS) begin
				return 0;
			end
			c = longint'(coef_e12(5'(j)));
			mag = (c < 0) ? -c : c;
			q = (mag * (longint'(1) <<< bits) + 64'sd500000000000) / 64'sd1000000000000;
			return (c < 0) ? -q : q;
		end
	endfunction

endpackage

@@ hw/rtl/encoder_angle_velocity_filter_core.sv @@
// top level: angle unwrap, fir lowpass, differentiator and two moving averages
//
// One beat in gives one beat out. A primed sample passes through an unwrap step, the FIR
// (one tap a cycle from the angle history memory), a drain of the multiply pipeline and a
// read of the velocity histories. Each moving average then does one read-modify-write of
// its history memory and the divide by TAPS (a reciprocal multiply done as four partial
// products). Last come the load of the output register and the output beat. A warm-up
// sample goes from the unwrap step straight to the output register. Histories are circular
// buffers sharing a write pointer, so no memory clearing is needed. The FIR only runs once
// TAPS angles have been written. A fill count makes unwritten velocity entries read as
// zero. The input takes the next beat only once the previous result has left the output
// register. Configuration writes apply to the next sample only if the user makes them
// while idle; the block itself does not enforce this.
module encoder_angle_velocity_filter_core
	import eavf_pkg::*;
#(
	parameter int TAPS = 34,
	parameter int COEF_BITS = 18
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [14:0]        raw_angle,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] smoothed_velocity,
	output logic signed [31:0] first_velocity,
	output logic               primed,
	output logic               turn_overflow,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	localparam int AW = $clog2(TAPS);
	localparam int CW = $clog2(TAPS + 1);
	localparam logic [AW-1:0] LAST = AW'(TAPS - 1);
	localparam int DIV_K = 38 + $clog2(TAPS);
	localparam longint RECIP_L = ((longint'(1) <<< DIV_K) + longint'(TAPS) - 1)
		/ longint'(TAPS);
	localparam logic [39:0] RECIP = 40'(RECIP_L);
	localparam logic [2:0] DV_LAST = 3'd5;

	typedef logic [AW-1:0] addr_t;

	function automatic addr_t wrap_inc(input addr_t a);
		return (a == LAST) ? '0 : a + addr_t'(1);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	state_t state_q, state_d;

	logic [15:0] sample_rate_q;
	logic [14:0] wrap_thr_q;
	logic [14:0] prev_raw_q;
	logic [14:0] raw_q;
	logic signed [15:0] turn_q;
	logic signed [31:0] prev_filt_q;
	logic signed [31:0] unwrapped_q;
	logic signed [39:0] sum1_q, sum2_q;
	logic [CW-1:0] warm_q;
	logic [CW-1:0] vfill_q;
	logic ovf_q;
	logic prim_item_q;
	addr_t wp_q;
	addr_t rd_q;
	addr_t tap_q;
	logic tap_ok_s1;
	addr_t tap_s1;
	logic signed [63:0] acc_q;
	logic signed [31:0] first_q;
	logic signed [31:0] vel_in_q;
	logic [2:0] dv_cnt_q;
	logic [37:0] dv_mag_q;
	logic dv_neg_q;
	logic [79:0] dv_acc_q;

	logic signed [31:0] ang_mem [TAPS];
	logic signed [31:0] v1_mem [TAPS];
	logic signed [31:0] v2_mem [TAPS];
	logic signed [31:0] ang_rd_s1, v1_rd_s1, v2_rd_s1;
	logic signed [63:0] prod_s2;
	logic prod_ok_s2;

	logic signed [COEF_BITS+7:0] coef_tab [TAPS];

	logic ang_we, v1_we, v2_we;
	logic signed [31:0] ang_wd;
	logic do_fir;
	logic signed [63:0] rounded;
	logic signed [31:0] filtered;
	logic signed [31:0] v1_old, v2_old;
	logic signed [39:0] s1_new, s2_new;
	logic [63:0] acc_mag;
	logic signed [39:0] dv_src;
	logic [37:0] dv_start_mag;
	logic [18:0] dv_a;
	logic [19:0] dv_b;
	logic [38:0] dv_pp;
	logic [79:0] dv_pp_sh;
	logic [31:0] dv_q_mag;
	logic signed [31:0] dv_res;

	logic signed [16:0] diff;
	logic signed [15:0] turn_next;
	logic set_ovf;
	logic signed [31:0] unwrap_val;

	for (genvar g = 0; g < TAPS; g++) begin : g_coef
		assign coef_tab[g] = (COEF_BITS+8)'(coef_scaled((TAPS - 1 - g < g) ? TAPS - 1 - g : g,
			COEF_BITS));
	end

	assign in_stall = (state_q != ST_IDLE) || out_valid;
	assign do_fir = (warm_q == CW'(TAPS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_q <= 16'd1000;
			wrap_thr_q <= 15'd16000;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_SAMPLE_RATE: sample_rate_q <= cfg_data;
				REG_WRAP_THRESHOLD: wrap_thr_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid && !in_stall) state_d = ST_UNWRAP;
			ST_UNWRAP: state_d = do_fir ? ST_FIR : ST_OUT;
			ST_FIR: if (tap_q == LAST) state_d = ST_FINISH;
			ST_FINISH: if (!tap_ok_s1 && !prod_ok_s2) state_d = ST_VEL;
			ST_VEL: state_d = ST_AVG1;
			ST_AVG1: if (dv_cnt_q == DV_LAST) state_d = ST_AVG2;
			ST_AVG2: if (dv_cnt_q == DV_LAST) state_d = ST_OUT;
			ST_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ang_we = (state_q == ST_UNWRAP);
		ang_wd = unwrapped_q;
		v1_we = (state_q == ST_AVG1) && (dv_cnt_q == '0);
		v2_we = (state_q == ST_AVG2) && (dv_cnt_q == '0);
		acc_mag = acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
		acc_mag = (acc_mag + (64'd1 << (COEF_BITS - 1))) >> COEF_BITS;
		rounded = acc_q[63] ? -$signed(acc_mag) : $signed(acc_mag);
		filtered = sat32(rounded);
		// velocity entries not yet written read as zero
		v1_old = (vfill_q == CW'(TAPS)) ? v1_rd_s1 : 32'sd0;
		v2_old = (vfill_q == CW'(TAPS)) ? v2_rd_s1 : 32'sd0;
		s1_new = sum1_q - 40'(v1_old) + 40'(first_q);
		s2_new = sum2_q - 40'(v2_old) + 40'(vel_in_q);
		// divide by TAPS: magnitude times reciprocal, truncated toward zero
		dv_src = (state_q == ST_AVG2) ? s2_new : s1_new;
		dv_start_mag = dv_src[39] ? 38'(-dv_src) : 38'(dv_src);
		dv_a = (dv_cnt_q == 3'd2 || dv_cnt_q == 3'd4) ? dv_mag_q[37:19] : dv_mag_q[18:0];
		dv_b = (dv_cnt_q >= 3'd3) ? RECIP[39:20] : RECIP[19:0];
		dv_pp = 39'(dv_a) * 39'(dv_b);
		case (dv_cnt_q)
			3'd2: dv_pp_sh = 80'(dv_pp) << 19;
			3'd3: dv_pp_sh = 80'(dv_pp) << 20;
			3'd4: dv_pp_sh = 80'(dv_pp) << 39;
			default: dv_pp_sh = 80'(dv_pp);
		endcase
		dv_q_mag = 32'(dv_acc_q >> DIV_K);
		dv_res = dv_neg_q ? -$signed(dv_q_mag) : $signed(dv_q_mag);
	end

	// oldest entry sits at the write pointer
	always_ff @(posedge clk) begin
		if (ang_we) ang_mem[wp_q] <= ang_wd;
		if (v1_we) v1_mem[wp_q] <= first_q;
		if (v2_we) v2_mem[wp_q] <= vel_in_q;
		ang_rd_s1 <= ang_mem[rd_q];
		v1_rd_s1 <= v1_mem[wp_q];
		v2_rd_s1 <= v2_mem[wp_q];
		prod_s2 <= 64'(ang_rd_s1) * 64'(coef_tab[tap_s1]);
	end

	always_comb begin
		diff = $signed({2'b0, raw_angle}) - $signed({2'b0, prev_raw_q});
		turn_next = turn_q;
		set_ovf = 1'b0;
		if (warm_q != '0) begin
			if (diff > $signed({2'b0, wrap_thr_q})) begin
				if (turn_q == -16'sd32768) set_ovf = 1'b1;
				else turn_next = turn_q - 16'sd1;
			end else if (-diff > $signed({2'b0, wrap_thr_q})) begin
				if (turn_q == 16'sd32767) set_ovf = 1'b1;
				else turn_next = turn_q + 16'sd1;
			end
		end
		unwrap_val = $signed({17'd0, raw_angle}) + 32'(turn_next) * 32'sd23040;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) prim_item_q <= 1'b0;
		else if (state_q == ST_UNWRAP) prim_item_q <= do_fir;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			prev_raw_q <= '0;
			raw_q <= '0;
			turn_q <= '0;
			prev_filt_q <= '0;
			unwrapped_q <= '0;
			sum1_q <= '0;
			sum2_q <= '0;
			warm_q <= '0;
			vfill_q <= '0;
			ovf_q <= 1'b0;
			wp_q <= '0;
			rd_q <= '0;
			tap_q <= '0;
			tap_ok_s1 <= 1'b0;
			tap_s1 <= '0;
			prod_ok_s2 <= 1'b0;
			acc_q <= '0;
			first_q <= '0;
			vel_in_q <= '0;
			dv_cnt_q <= '0;
			dv_mag_q <= '0;
			dv_neg_q <= 1'b0;
			dv_acc_q <= '0;
			out_valid <= 1'b0;
			smoothed_velocity <= '0;
			first_velocity <= '0;
			primed <= 1'b0;
			turn_overflow <= 1'b0;
		end else begin
			state_q <= state_d;
			tap_ok_s1 <= (state_q == ST_FIR);
			tap_s1 <= tap_q;
			prod_ok_s2 <= tap_ok_s1;
			if (prod_ok_s2) acc_q <= acc_q + prod_s2;
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (state_q == ST_AVG1 || state_q == ST_AVG2) begin
				if (dv_cnt_q == '0) begin
					dv_mag_q <= dv_start_mag;
					dv_neg_q <= dv_src[39];
					dv_acc_q <= '0;
					dv_cnt_q <= 3'd1;
				end else if (dv_cnt_q == DV_LAST) begin
					dv_cnt_q <= '0;
				end else begin
					dv_acc_q <= dv_acc_q + dv_pp_sh;
					dv_cnt_q <= dv_cnt_q + 3'd1;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid && !in_stall) begin
						raw_q <= raw_angle;
					end
				end
				ST_UNWRAP: begin
					// turn update already applied via unwrapped_q below
					prev_raw_q <= raw_q;
					wp_q <= wrap_inc(wp_q);
					rd_q <= wrap_inc(wp_q);
					tap_q <= '0;
					acc_q <= '0;
					if (!do_fir) begin
						prev_filt_q <= unwrapped_q;
						warm_q <= warm_q + CW'(1);
						first_q <= '0;
						vel_in_q <= '0;
					end
				end
				ST_FIR: begin
					rd_q <= wrap_inc(rd_q);
					tap_q <= tap_q + addr_t'(1);
				end
				ST_FINISH: begin
					if (!tap_ok_s1 && !prod_ok_s2) begin
						first_q <= sat32((64'(filtered) - 64'(prev_filt_q))
							* $signed({48'd0, sample_rate_q}));
						prev_filt_q <= filtered;
						wp_q <= (wp_q == '0) ? LAST : wp_q - addr_t'(1);
					end
				end
				ST_VEL: ;
				ST_AVG1: begin
					if (dv_cnt_q == '0) sum1_q <= s1_new;
					else if (dv_cnt_q == DV_LAST) vel_in_q <= dv_res;
				end
				ST_AVG2: begin
					if (dv_cnt_q == '0) begin
						sum2_q <= s2_new;
					end else if (dv_cnt_q == DV_LAST) begin
						vel_in_q <= dv_res;
						wp_q <= wrap_inc(wp_q);
						if (vfill_q != CW'(TAPS)) vfill_q <= vfill_q + CW'(1);
					end
				end
				ST_OUT: begin
					out_valid <= 1'b1;
					first_velocity <= first_q;
					smoothed_velocity <= vel_in_q;
					primed <= prim_item_q;
					turn_overflow <= ovf_q;
				end
				default: ;
			endcase
			// unwrap happens in the accept cycle
			if (state_q == ST_IDLE && in_valid && !in_stall) begin
				unwrapped_q <= unwrap_val;
				turn_q <= turn_next;
				if (set_ovf) ovf_q <= 1'b1;
			end
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("input accepted while busy");
	a_out_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_OUT)
		else $error("result without item");
	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(ovf_q) |-> ovf_q)
		else $error("overflow flag cleared");

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the encoder angle velocity filter core
`timescale 1ns / 1ps

module testbench
	import eavf_pkg::*;
();

	typedef struct {
		logic signed [31:0] smooth;
		logic signed [31:0] first;
		logic               primed;
		logic               ovf;
	} velocity_beat_t;

	class velocity_scoreboard;
		localparam int N = 34;
		velocity_beat_t pending[$];
		longint coef[N];
		int rate;
		int threshold;
		int angle_hist[N];
		int vel_hist_a[N];
		int vel_hist_b[N];
		longint sum_a;
		longint sum_b;
		int last_raw;
		int turns;
		int last_filtered;
		int warm;
		bit ovf_flag;
		int mismatches;
		int checked;
		int primed_seen;

		function new();
			longint e12[17];
			longint c;
			longint mag;
			longint q;
			int j;
			e12 = '{64'sd298910, 64'sd1959461, 64'sd2847098, -64'sd25211439,
				-64'sd195788766, -64'sd789310970, -64'sd2259462042, -64'sd4986784693,
				-64'sd8656045842, -64'sd11429277453, -64'sd9517036757, 64'sd2063978790,
				64'sd27224499002, 64'sd65794886477, 64'sd111565845660, 64'sd153155814566,
				64'sd178048771809};
			for (int i = 0; i < N; i++) begin
				j = (N - 1 - i < i) ? N - 1 - i : i;
				c = e12[j];
				mag = c < 0 ? -c : c;
				q = (mag * (longint'(1) << 18) + 64'sd500000000000) / 64'sd1000000000000;
				coef[i] = c < 0 ? -q : q;
			end
			rate = 1000;
			threshold = 16000;
			sum_a = 0;
			sum_b = 0;
			last_raw = 0;
			turns = 0;
			last_filtered = 0;
			warm = 0;
			ovf_flag = 0;
			mismatches = 0;
			checked = 0;
			primed_seen = 0;
			for (int i = 0; i < N; i++) begin
				angle_hist[i] = 0;
				vel_hist_a[i] = 0;
				vel_hist_b[i] = 0;
			end
		endfunction

		function void set_reg(reg_index_t idx, logic [15:0] value);
			if (idx == REG_SAMPLE_RATE)
				rate = value;
			else
				threshold = value[14:0];
		endfunction

		function longint clip32(longint v);
			if (v > 64'sd2147483647)
				return 64'sd2147483647;
			if (v < -64'sd2147483648)
				return -64'sd2147483648;
			return v;
		endfunction

		function void note_angle(logic [14:0] raw);
			velocity_beat_t e;
			int diff;
			int unwrapped;
			longint acc;
			longint mag;
			longint rounded;
			longint filtered;
			longint first;
			longint avg;
			e.smooth = 0;
			e.first = 0;
			e.primed = 0;
			if (warm > 0) begin
				diff = int'(raw) - last_raw;
				if (diff > threshold) begin
					if (turns <= -32768)
						ovf_flag = 1;
					else
						turns--;
				end else if (-diff > threshold) begin
					if (turns >= 32767)
						ovf_flag = 1;
					else
						turns++;
				end
			end
			last_raw = raw;
			unwrapped = int'(raw) + turns * TURN_UNITS;
			for (int i = 0; i < N - 1; i++)
				angle_hist[i] = angle_hist[i + 1];
			angle_hist[N - 1] = unwrapped;
			if (warm < N) begin
				last_filtered = unwrapped;
				warm++;
			end else begin
				acc = 0;
				for (int i = 0; i < N; i++)
					acc += longint'(angle_hist[i]) * coef[i];
				mag = acc < 0 ? -acc : acc;
				rounded = (mag + (longint'(1) << 17)) >>> 18;
				filtered = clip32(acc < 0 ? -rounded : rounded);
				first = clip32((filtered - last_filtered) * rate);
				last_filtered = int'(filtered);
				sum_a -= vel_hist_a[0];
				for (int i = 0; i < N - 1; i++)
					vel_hist_a[i] = vel_hist_a[i + 1];
				vel_hist_a[N - 1] = int'(first);
				sum_a += first;
				avg = sum_a / N;
				sum_b -= vel_hist_b[0];
				for (int i = 0; i < N - 1; i++)
					vel_hist_b[i] = vel_hist_b[i + 1];
				vel_hist_b[N - 1] = int'(avg);
				sum_b += avg;
				e.smooth = 32'(sum_b / N);
				e.first = 32'(first);
				e.primed = 1;
			end
			e.ovf = ovf_flag;
			pending.push_back(e);
		endfunction

		function void check_beat(logic signed [31:0] smooth, logic signed [31:0] first,
				logic primed, logic ovf);
			velocity_beat_t e;
			checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: smooth %0d first %0d", smooth, first);
				return;
			end
			e = pending.pop_front();
			if (primed)
				primed_seen++;
			if (smooth !== e.smooth || first !== e.first || primed !== e.primed ||
					ovf !== e.ovf) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch beat %0d: exp %0d %0d %0b %0b got %0d %0d %0b %0b",
						checked, e.smooth, e.first, e.primed, e.ovf,
						smooth, first, primed, ovf);
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [14:0]        raw_angle;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] smoothed_velocity;
	logic signed [31:0] first_velocity;
	logic               primed;
	logic               turn_overflow;
	logic               cfg_we;
	logic [0:0]         cfg_index;
	logic [15:0]        cfg_data;

	velocity_scoreboard sb;
	bit calm;
	bit long_hold;
	int sent;
	int pos;
	int speed;

	encoder_angle_velocity_filter_core dut (.*);

	initial clk = 0;
	always #10 clk = ~clk;

	initial begin
		#40ms;
		$display("tb: failure");
		$finish;
	end

	// receiver: random stalls, one long hold-off when asked
	initial begin
		int left;
		int r;
		left = 0;
		out_stall = 0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				long_hold = 0;
				left = 700;
			end
			if (left > 0) begin
				left--;
				out_stall <= 1;
			end else if (calm) begin
				out_stall <= 0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70)
					out_stall <= 0;
				else begin
					out_stall <= 1;
					left = (r < 96) ? $urandom_range(0, 4) : $urandom_range(20, 150);
				end
			end
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check_beat(smoothed_velocity, first_velocity, primed, turn_overflow);

	task automatic send_angle(logic [14:0] a);
		int g;
		in_valid <= 1;
		raw_angle <= a;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_angle(a);
		sent++;
		g = calm ? 0 : ($urandom_range(0, 9) < 6 ? 0 :
			($urandom_range(0, 19) == 0 ? $urandom_range(30, 200) : $urandom_range(1, 5)));
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic write_reg(reg_index_t idx, logic [15:0] value);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, value);
		@(posedge clk);
	endtask

	task automatic settle();
		in_valid <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	function automatic logic [14:0] pick_angle();
		if ($urandom_range(0, 99) < 80) begin
			if ($urandom_range(0, 39) == 0)
				speed = $urandom_range(0, 1) ? $urandom_range(0, 3000) :
					-$urandom_range(0, 3000);
			pos = (pos + speed + TURN_UNITS) % TURN_UNITS;
			return 15'(pos);
		end
		return $urandom_range(0, 99) < 50 ? 15'($urandom_range(0, 32767)) :
			15'($urandom_range(0, 23039));
	endfunction

	task automatic run_random(int n);
		for (int k = 0; k < n; k++)
			send_angle(pick_angle());
	endtask

	initial begin
		logic [14:0] directed[$];
		sb = new();
		arst_n = 0;
		in_valid = 0;
		raw_angle = 0;
		cfg_we = 0;
		cfg_index = REG_SAMPLE_RATE;
		cfg_data = 0;
		calm = 0;
		long_hold = 0;
		sent = 0;
		pos = 0;
		speed = 150;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// zero-crossings both ways, range edges and out-of-range angles
		directed = '{15'd23039, 15'd0, 15'd23039, 15'd0, 15'd32767, 15'd0, 15'd100,
			15'd22900, 15'd16384, 15'd11520, 15'd5000, 15'd21000, 15'd500, 15'd1,
			15'd23038, 15'd32767, 15'd16383, 15'd0, 15'd23039, 15'd7000};
		foreach (directed[k])
			send_angle(directed[k]);
		run_random(170);
		settle();

		write_reg(REG_SAMPLE_RATE, 16'd65535);
		write_reg(REG_WRAP_THRESHOLD, 16'd0);
		long_hold = 1;
		run_random(170);
		settle();

		write_reg(REG_SAMPLE_RATE, 16'd1);
		write_reg(REG_WRAP_THRESHOLD, 16'd23039);
		calm = 1;
		run_random(170);
		calm = 0;
		settle();

		write_reg(REG_SAMPLE_RATE, 16'd0);
		write_reg(REG_WRAP_THRESHOLD, 16'hFFFF);
		run_random(170);
		settle();

		write_reg(REG_SAMPLE_RATE, 16'($urandom_range(2, 65534)));
		write_reg(REG_WRAP_THRESHOLD, 16'($urandom_range(0, 23039)));
		run_random(170);
		settle();

		write_reg(REG_SAMPLE_RATE, 16'd65535);
		write_reg(REG_WRAP_THRESHOLD, 16'd11520);
		run_random(170);
		settle();

		$display("run: %0d angle beats sent, %0d results checked, %0d primed", sent,
			sb.checked, sb.primed_seen);
		$display("six register settings incl. zero and full-scale rate, zero threshold");
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
